/* design/irpw_pkg.sv */
// Package for the IR pulse-width transceiver.
// Opcodes, register indexes, reset values and shared structs; no dependencies.
package irpw_pkg;

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_SEND = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS    = 3'd5;

  localparam logic [15:0] RST_START_MIN    = 16'd200;
  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd10000;
  localparam logic [7:0]  RST_START_TICKS  = 8'd80;
  localparam logic [7:0]  RST_GAP_TICKS    = 8'd40;
  localparam logic [7:0]  RST_ZERO_TICKS   = 8'd20;
  localparam logic [7:0]  RST_ONE_TICKS    = 8'd60;

  // start burst phase; phases count down to the final on tick at zero
  localparam logic [4:0] PHASE_START = 5'd18;
  localparam logic [4:0] PHASE_LAST  = 5'd0;
  localparam logic [3:0] RX_BITS     = 4'd8;

  typedef struct packed {
    logic [15:0] start_min_us;
    logic [15:0] idle_timeout_us;
    logic [7:0]  start_ticks;
    logic [7:0]  gap_ticks;
    logic [7:0]  zero_ticks;
    logic [7:0]  one_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_byte_valid;
    logic       rx_done;
  } rx_res_t;

  typedef struct packed {
    logic carrier_on;
    logic tx_busy;
    logic tx_accepted;
  } tx_res_t;

endpackage

/* design/ir_pulse_width_transceiver.sv */
// Top level of the IR pulse-width transceiver: input register, rx/tx update, result register.
// Depends on irpw_pkg, irpw_cfg, irpw_rx, irpw_tx.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: a pin edge
//   with its microsecond stamp, a transmit request with a byte, or a carrier tick.
//   Every item produces exactly one result transfer on out_valid/out_stall
//   showing receive status, carrier enable and transmitter status after the item.
//   Pipeline: an item passes the input register, then the result register,
//   whose contents are offered on out_valid; a stall can hold it in either.
//   Throughput: one item per cycle while out_stall is low; the rx and tx state
//   update as an item moves from the input register to the result register.
//   Stall: while the result register holds an untaken result and out_stall is
//   high, the input register keeps its item and in_stall rises once it is full;
//   up to two items sit in the block before in_stall asserts.
//   Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data;
//   cfg_ready is always high. Write only while the block holds no item.
//   Reset (rst_n low, synchronous): receiver idle, transmitter idle, carrier
//   off, both pipeline registers empty, registers back to their defaults.
module ir_pulse_width_transceiver
  import irpw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic                 in_pin_level,
  input  logic [15:0]          in_now_us,
  input  logic [7:0]           in_tx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_rx_byte,
  output logic                 out_rx_byte_valid,
  output logic                 out_rx_done,
  output logic                 out_carrier_on,
  output logic                 out_tx_busy,
  output logic                 out_tx_accepted,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t    cfg;
  rx_res_t rx_res;
  tx_res_t tx_res;
  logic    tx_sending;

  // input register
  logic        in_valid_r;
  logic [1:0]  op_r;
  logic        level_r;
  logic [15:0] now_r;
  logic [7:0]  byte_r;

  // result register
  logic        out_valid_r;
  rx_res_t     rx_out_r;
  tx_res_t     tx_out_r;

  logic out_free;
  logic advance;
  opcode_t op;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;   // state update happens here
  assign in_stall = in_valid_r && !out_free;
  assign op       = opcode_t'(op_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_opcode;
      level_r <= in_pin_level;
      now_r   <= in_now_us;
      byte_r  <= in_tx_byte;
    end
  end

  irpw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // receiver drops any open frame on edges while the transmitter is busy
  irpw_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .op         (op),
    .pin_level  (level_r),
    .now_us     (now_r),
    .tx_sending (tx_sending),
    .cfg        (cfg),
    .res        (rx_res)
  );

  irpw_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .op         (op),
    .tx_byte    (byte_r),
    .cfg        (cfg),
    .tx_sending (tx_sending),
    .res        (tx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rx_out_r <= rx_res;
      tx_out_r <= tx_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rx_byte       = rx_out_r.rx_byte;
  assign out_rx_byte_valid = rx_out_r.rx_byte_valid;
  assign out_rx_done       = rx_out_r.rx_done;
  assign out_carrier_on    = tx_out_r.carrier_on;
  assign out_tx_busy       = tx_out_r.tx_busy;
  assign out_tx_accepted   = tx_out_r.tx_accepted;

  // a taken request always starts with the carrier on
  a_accept_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_accepted |-> out_carrier_on && out_tx_busy)
    else $error("accepted request without carrier and busy");

  // carrier only runs inside a transmission
  a_carrier_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carrier_on |-> out_tx_busy)
    else $error("carrier on while transmitter idle");

  // a completed byte is always marked valid
  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_done |-> out_rx_byte_valid)
    else $error("rx_done without rx_byte_valid");

  // input side only stalls when the result register is blocked
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

endmodule

/* design/irpw_cfg.sv */
// Configuration register file of the IR transceiver.
// Depends on irpw_pkg.
module irpw_cfg
  import irpw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_START_MIN:    cfg_nxt.start_min_us    = wr_data;
        REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout_us = wr_data;
        REG_START_TICKS:  cfg_nxt.start_ticks     = wr_data[7:0];
        REG_GAP_TICKS:    cfg_nxt.gap_ticks       = wr_data[7:0];
        REG_ZERO_TICKS:   cfg_nxt.zero_ticks      = wr_data[7:0];
        REG_ONE_TICKS:    cfg_nxt.one_ticks       = wr_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min_us    <= RST_START_MIN;
      cfg_r.idle_timeout_us <= RST_IDLE_TIMEOUT;
      cfg_r.start_ticks     <= RST_START_TICKS;
      cfg_r.gap_ticks       <= RST_GAP_TICKS;
      cfg_r.zero_ticks      <= RST_ZERO_TICKS;
      cfg_r.one_ticks       <= RST_ONE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/irpw_rx.sv */
// Pulse-width receiver: start detection, bit slicing, frame abort.
// Depends on irpw_pkg.
module irpw_rx
  import irpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  opcode_t     op,
  input  logic        pin_level,
  input  logic [15:0] now_us,
  input  logic        tx_sending,
  input  cfg_t        cfg,
  output rx_res_t     res
);

  logic [15:0] last_edge_r, last_edge_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [14:0] thr_r, thr_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        valid_r, valid_nxt;
  logic        done;
  logic [15:0] elapsed;

  assign elapsed = now_us - last_edge_r;

  always_comb begin
    last_edge_nxt = last_edge_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    thr_nxt       = thr_r;
    byte_nxt      = byte_r;
    valid_nxt     = valid_r;
    done          = 1'b0;
    if (en && (op == OP_EDGE)) begin
      if (tx_sending) begin
        // own transmission echoes: drop any frame, keep the time base
        bits_left_nxt = 4'd0;
      end else begin
        last_edge_nxt = now_us;
        if (pin_level) begin
          if (bits_left_r == 4'd0) begin
            if (elapsed > cfg.start_min_us) begin
              thr_nxt       = elapsed[15:1];
              shift_nxt     = 8'd0;
              bits_left_nxt = RX_BITS;
              valid_nxt     = 1'b0;
            end
          end else begin
            shift_nxt     = {shift_r[6:0], (elapsed > {1'b0, thr_r})};
            bits_left_nxt = bits_left_r - 4'd1;
            if (bits_left_r == 4'd1) begin
              byte_nxt  = {shift_r[6:0], (elapsed > {1'b0, thr_r})};
              valid_nxt = 1'b1;
              done      = 1'b1;
            end
          end
        end else if (elapsed > cfg.idle_timeout_us) begin
          bits_left_nxt = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      bits_left_r <= '0;
      shift_r     <= '0;
      thr_r       <= '0;
      byte_r      <= '0;
      valid_r     <= 1'b0;
    end else begin
      last_edge_r <= last_edge_nxt;
      bits_left_r <= bits_left_nxt;
      shift_r     <= shift_nxt;
      thr_r       <= thr_nxt;
      byte_r      <= byte_nxt;
      valid_r     <= valid_nxt;
    end
  end

  assign res.rx_byte       = byte_nxt;
  assign res.rx_byte_valid = valid_nxt;
  assign res.rx_done       = done;

endmodule

/* design/irpw_tx.sv */
// Pulse-width transmitter: phase sequencer and burst tick counter.
// Depends on irpw_pkg.
module irpw_tx
  import irpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  opcode_t    op,
  input  logic [7:0] tx_byte,
  input  cfg_t       cfg,
  output logic       tx_sending,
  output tx_res_t    res
);

  logic       pending_r, pending_nxt;
  logic [4:0] phase_r, phase_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       carrier_r, carrier_nxt;
  logic       accepted;
  logic [7:0] ticks_dec;
  logic [4:0] phase_dec;

  assign ticks_dec = ticks_r - 8'd1;
  assign phase_dec = phase_r - 5'd1;

  always_comb begin
    pending_nxt = pending_r;
    phase_nxt   = phase_r;
    ticks_nxt   = ticks_r;
    shift_nxt   = shift_r;
    carrier_nxt = carrier_r;
    accepted    = 1'b0;
    if (en) begin
      case (op)
        OP_SEND: begin
          if (!pending_r) begin
            shift_nxt   = tx_byte;
            phase_nxt   = PHASE_START;
            ticks_nxt   = cfg.start_ticks;
            carrier_nxt = 1'b1;
            pending_nxt = 1'b1;
            accepted    = 1'b1;
          end
        end
        OP_TICK: begin
          if (phase_r != PHASE_LAST) begin
            ticks_nxt = ticks_dec;
            if (ticks_dec == 8'd0) begin
              carrier_nxt = ~carrier_r;
              phase_nxt   = phase_dec;
              if (phase_dec == PHASE_LAST) begin
                ticks_nxt = 8'd0;
              end else if (phase_dec[0]) begin
                ticks_nxt = cfg.gap_ticks;
              end else begin
                ticks_nxt = shift_r[7] ? cfg.one_ticks : cfg.zero_ticks;
                shift_nxt = {shift_r[6:0], 1'b0};
              end
            end
          end else if (pending_r) begin
            carrier_nxt = 1'b0;
            pending_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      phase_r   <= '0;
      ticks_r   <= '0;
      shift_r   <= '0;
      carrier_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      phase_r   <= phase_nxt;
      ticks_r   <= ticks_nxt;
      shift_r   <= shift_nxt;
      carrier_r <= carrier_nxt;
    end
  end

  assign tx_sending      = pending_r;
  assign res.carrier_on  = carrier_nxt;
  assign res.tx_busy     = pending_nxt;
  assign res.tx_accepted = accepted;

endmodule

/* bench/tb_ir_pulse_width_transceiver.sv */
// Self-checking bench for the IR pulse-width transceiver: directed and random traffic,
// a cycle-level predictor of receive/transmit status, varied stalls and a long hold-off.
// Depends on irpw_pkg and ir_pulse_width_transceiver.
module tb_ir_pulse_width_transceiver;
  import irpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on any channel before the run is declared hung.
  // Worst quiet stretch is the HOLDOFF_LEN hold-off plus random stalls around it.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLDOFF_LEN  = 300;
  localparam int unsigned PHASE_ITEMS  = 60;

  // Writes beyond the last register; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = REG_ONE_TICKS + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = REG_ONE_TICKS + 3'd2;

  // Status after one item, in the order the result ports carry it.
  typedef struct packed {
    rx_res_t rx;
    tx_res_t tx;
  } status_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = '0;
  logic                 in_pin_level = 1'b0;
  logic [15:0]          in_now_us = '0;
  logic [7:0]           in_tx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_rx_byte;
  logic                 out_rx_byte_valid;
  logic                 out_rx_done;
  logic                 out_carrier_on;
  logic                 out_tx_busy;
  logic                 out_tx_accepted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  ir_pulse_width_transceiver uut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copy plus receiver and transmitter state.
  // ---------------------------------------------------------------------------
  cfg_t        model_cfg = '{RST_START_MIN, RST_IDLE_TIMEOUT, RST_START_TICKS,
                             RST_GAP_TICKS, RST_ZERO_TICKS, RST_ONE_TICKS};
  logic [15:0] rx_prev_stamp = '0;   // time of the last edge the receiver took
  logic [3:0]  rx_bits_to_go = '0;   // zero while no frame is open
  logic [7:0]  rx_acc = '0;
  logic [14:0] rx_half_low = '0;     // half the start low period, the bit threshold
  logic [7:0]  rx_last_byte = '0;
  logic        rx_last_ok = 1'b0;
  logic        tx_active = 1'b0;
  logic [4:0]  tx_phase = '0;
  logic [7:0]  tx_count = '0;
  logic [7:0]  tx_data = '0;
  logic        tx_carrier = 1'b0;

  status_t     predicted_status[$];  // one entry per accepted item, oldest first
  int unsigned mismatches = 0;
  int unsigned effective_items = 0;  // items that can change state
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holdoff_cycles = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] stamp_us = 16'hFF00;  // running pin time; starts near the wrap

  // Length of the phase just entered; bit bursts consume the next MSB.
  function automatic logic [7:0] burst_len(input logic [4:0] idx);
    logic [7:0] len;
    if (idx == PHASE_LAST) return 8'd0;
    if (idx[0]) return model_cfg.gap_ticks;
    len = tx_data[7] ? model_cfg.one_ticks : model_cfg.zero_ticks;
    tx_data = {tx_data[6:0], 1'b0};
    return len;
  endfunction

  function automatic status_t advance_transceiver(input opcode_t op, input logic lvl,
                                                  input logic [15:0] now,
                                                  input logic [7:0] data);
    status_t     s;
    logic [15:0] elapsed;
    s = '0;
    elapsed = now - rx_prev_stamp;  // wraps mod 2^16
    case (op)
      OP_EDGE: begin
        if (tx_active) begin
          // own carrier on the pin: drop the frame, keep the old edge time
          rx_bits_to_go = '0;
        end else begin
          if (lvl) begin
            if (rx_bits_to_go == '0) begin
              if (elapsed > model_cfg.start_min_us) begin
                rx_half_low   = elapsed[15:1];
                rx_acc        = '0;
                rx_bits_to_go = RX_BITS;
                rx_last_ok    = 1'b0;
              end
            end else begin
              rx_acc        = {rx_acc[6:0], elapsed > {1'b0, rx_half_low}};
              rx_bits_to_go = rx_bits_to_go - 4'd1;
              if (rx_bits_to_go == '0) begin
                rx_last_byte   = rx_acc;
                rx_last_ok     = 1'b1;
                s.rx.rx_done   = 1'b1;
              end
            end
          end else if (elapsed > model_cfg.idle_timeout_us) begin
            rx_bits_to_go = '0;
          end
          rx_prev_stamp = now;
        end
      end
      OP_SEND: begin
        if (!tx_active) begin
          tx_data          = data;
          tx_phase         = PHASE_START;
          tx_count         = model_cfg.start_ticks;
          tx_carrier       = 1'b1;
          tx_active        = 1'b1;
          s.tx.tx_accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (tx_phase != PHASE_LAST) begin
          tx_count = tx_count - 8'd1;  // a count of zero wraps to 256 ticks
          if (tx_count == '0) begin
            tx_carrier = !tx_carrier;
            tx_phase   = tx_phase - 5'd1;
            tx_count   = burst_len(tx_phase);
          end
        end else if (tx_active) begin
          tx_carrier = 1'b0;
          tx_active  = 1'b0;
        end
      end
      default: ;
    endcase
    s.rx.rx_byte       = rx_last_byte;
    s.rx.rx_byte_valid = rx_last_ok;
    s.tx.carrier_on    = tx_carrier;
    s.tx.tx_busy       = tx_active;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, hold-off on request, and the checker.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_cycles != 0) begin
        out_stall <= 1'b1;
        holdoff_cycles = holdoff_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_status.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transfer with nothing expected, expected none, actual %0h",
                 $time, {out_rx_byte, out_rx_byte_valid, out_rx_done,
                         out_carrier_on, out_tx_busy, out_tx_accepted});
      end else begin
        want = predicted_status.pop_front();
        check_field("rx_byte", want.rx.rx_byte, out_rx_byte);
        check_field("rx_byte_valid", 8'(want.rx.rx_byte_valid), 8'(out_rx_byte_valid));
        check_field("rx_done", 8'(want.rx.rx_done), 8'(out_rx_done));
        check_field("carrier_on", 8'(want.tx.carrier_on), 8'(out_carrier_on));
        check_field("tx_busy", 8'(want.tx.tx_busy), 8'(out_tx_busy));
        check_field("tx_accepted", 8'(want.tx.tx_accepted), 8'(out_tx_accepted));
      end
    end
  end

  // Hang detector: any transfer on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a rising edge.
  // ---------------------------------------------------------------------------

  // One input transfer. Valid stays high on return so back-to-back items
  // never see valid dropped and raised in the same step.
  task automatic send_item(input opcode_t op, input logic lvl, input logic [15:0] now,
                           input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_pin_level <= lvl;
    in_now_us    <= now;
    in_tx_byte   <= data;
    do @(posedge clk); while (in_stall);
    if (op != OP_NONE && !(op == OP_TICK && !tx_active)) effective_items++;
    predicted_status.push_back(advance_transceiver(op, lvl, now, data));
  endtask

  task automatic carrier_tick();
    send_item(OP_TICK, 1'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Pin edge 'delta' microseconds after the previous one.
  task automatic pin_edge(input logic lvl, input int unsigned delta);
    stamp_us = stamp_us + 16'(delta);
    send_item(OP_EDGE, lvl, stamp_us, 8'($urandom));
  endtask

  task automatic noise_item();
    opcode_t     op;
    logic [15:0] now;
    op  = opcode_t'($urandom_range(3));
    now = ($urandom_range(3) == 0) ? 16'($urandom) : stamp_us + 16'($urandom_range(400));
    if (op == OP_EDGE) stamp_us = now;
    send_item(op, 1'($urandom), now, 8'($urandom));
  endtask

  task automatic finish_transmission();
    while (tx_active) carrier_tick();
  endtask

  // Whole frame: long high to clear any open frame, start low, then 8 bits
  // MSB first. break_bit >= 0 puts an over-long high before that bit.
  task automatic send_rx_frame(input logic [7:0] data, input int unsigned start_low,
                               input int unsigned high_max, input int break_bit);
    int unsigned half;
    if (model_cfg.idle_timeout_us < 16'd65000)
      pin_edge(1'b0, model_cfg.idle_timeout_us + 1 + $urandom_range(500));
    else
      pin_edge(1'b0, $urandom_range(high_max));
    pin_edge(1'b1, start_low);
    half = start_low / 2;
    for (int i = 7; i >= 0; i--) begin
      if (i == break_bit)
        pin_edge(1'b0, model_cfg.idle_timeout_us + 1 + $urandom_range(500));
      else
        pin_edge(1'b0, $urandom_range(high_max));
      pin_edge(1'b1, data[i] ? $urandom_range(2 * half + 1, half + 1) : $urandom_range(half));
    end
  endtask

  // Block is empty once every expected result is in; the extra cycles cover
  // the two-stage pipeline.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high so consecutive writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_MIN:    model_cfg.start_min_us    = value;
      REG_IDLE_TIMEOUT: model_cfg.idle_timeout_us = value;
      REG_START_TICKS:  model_cfg.start_ticks     = value[7:0];
      REG_GAP_TICKS:    model_cfg.gap_ticks       = value[7:0];
      REG_ZERO_TICKS:   model_cfg.zero_ticks      = value[7:0];
      REG_ONE_TICKS:    model_cfg.one_ticks       = value[7:0];
      default: ;
    endcase
  endtask

  // Full register load with the block idle; also pokes the two spare indexes.
  task automatic load_config(input cfg_t c);
    finish_transmission();
    wait_drained();
    write_reg(REG_START_MIN, c.start_min_us);
    write_reg(REG_IDLE_TIMEOUT, c.idle_timeout_us);
    write_reg(REG_START_TICKS, 16'(c.start_ticks));
    write_reg(REG_GAP_TICKS, 16'(c.gap_ticks));
    write_reg(REG_ZERO_TICKS, 16'(c.zero_ticks));
    write_reg(REG_ONE_TICKS, 16'(c.one_ticks));
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Receiver at reset settings: start threshold boundary, bit threshold
  // boundary, abort on a long high, then two full frames across the time wrap.
  task automatic test_rx_edges();
    pin_edge(1'b0, 100);
    pin_edge(1'b1, 200);   // equal to start_min: no frame
    pin_edge(1'b0, 50);
    pin_edge(1'b1, 201);   // frame starts, threshold 100
    pin_edge(1'b0, 10);
    pin_edge(1'b1, 100);   // at threshold: zero
    pin_edge(1'b0, 10);
    pin_edge(1'b1, 101);   // above threshold: one
    pin_edge(1'b0, 10001); // high too long: frame dropped
    pin_edge(1'b1, 5);
    send_rx_frame(8'hA5, 600, 10000, -1);
    send_rx_frame(8'h5A, 9000, 10000, -1);
  endtask

  // Transmit path with short phases: idle tick, unused opcode, request,
  // request while busy, edge while sending, then ticks to the end.
  task automatic test_tx_sequence();
    load_config('{RST_START_MIN, RST_IDLE_TIMEOUT, 8'd2, 8'd1, 8'd1, 8'd3});
    carrier_tick();
    send_item(OP_NONE, 1'b1, 16'hFFFF, 8'hFF);
    pin_edge(1'b0, 20000);
    pin_edge(1'b1, 400);   // frame open when the request lands
    send_item(OP_SEND, 1'b0, 16'h0000, 8'hB4);
    send_item(OP_SEND, 1'b1, 16'hFFFF, 8'h3C);
    pin_edge(1'b1, 300);   // sending: frame dropped, stamp kept
    send_item(OP_NONE, 1'b0, 16'h0000, 8'h00);
    finish_transmission();
    carrier_tick();
    pin_edge(1'b0, 40);
    pin_edge(1'b1, 300);
  endtask

  // Timing registers at their extremes.
  task automatic test_register_extremes();
    load_config('{16'hFFFF, 16'h0000, 8'd1, 8'd1, 8'd1, 8'd1});
    pin_edge(1'b0, 1);
    pin_edge(1'b1, 65535); // cannot exceed the maximum start length
    load_config('{16'h0000, 16'hFFFF, 8'd1, 8'd1, 8'd1, 8'd1});
    pin_edge(1'b1, 0);     // zero elapsed does not start
    pin_edge(1'b1, 1);     // starts, threshold 0
    pin_edge(1'b0, 65535); // never times out
    pin_edge(1'b1, 0);
    pin_edge(1'b0, 3);
    pin_edge(1'b1, 1);
    load_config('{16'h0000, 16'h0000, 8'd1, 8'd1, 8'd1, 8'd1});
    pin_edge(1'b1, 2);
    pin_edge(1'b0, 0);     // same instant: no timeout
    pin_edge(1'b1, 7);
    pin_edge(1'b0, 1);     // any high time aborts
    pin_edge(1'b1, 9);
  endtask

  // A zero start count wraps to a 256-tick burst; the other phases stay short.
  task automatic test_zero_tick_counts();
    load_config('{RST_START_MIN, RST_IDLE_TIMEOUT, 8'd0, 8'd1, 8'd1, 8'd1});
    send_item(OP_SEND, 1'b0, 16'h1234, 8'h5A);
    finish_transmission();
  endtask

  // Result side held off while the sender keeps offering: the block fills
  // and has to stall its input.
  task automatic test_backpressure();
    load_config('{16'd150, 16'd4000, 8'd2, 8'd1, 8'd2, 8'd3});
    holdoff_cycles = HOLDOFF_LEN;
    repeat (12) noise_item();
    send_rx_frame(8'($urandom), 500, 3000, -1);
    send_item(OP_SEND, 1'b0, 16'($urandom), 8'($urandom));
    finish_transmission();
  endtask

  // Random phases, one per idle/stall mode, each with fresh registers.
  // Most traffic is complete frames and transmissions with random content.
  task automatic test_random_traffic();
    cfg_t        c;
    int unsigned goal;
    int unsigned pick;
    int unsigned high_max;
    for (int ph = 0; ph < 4; ph++) begin
      c.start_min_us    = 16'($urandom_range(1500, 20));
      c.idle_timeout_us = 16'($urandom_range(30000, 2000));
      c.start_ticks     = 8'($urandom_range(4, 1));
      c.gap_ticks       = 8'($urandom_range(4, 1));
      c.zero_ticks      = 8'($urandom_range(4, 1));
      c.one_ticks       = 8'($urandom_range(4, 1));
      load_config(c);
      case (ph)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 76; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 76; end
        default: begin sender_idle_pct = 16; stall_pct = 16; end
      endcase
      high_max = (c.idle_timeout_us < 16'd3000) ? c.idle_timeout_us : 3000;
      goal = effective_items + PHASE_ITEMS;
      while (effective_items < goal) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          finish_transmission();
          send_rx_frame(8'($urandom), c.start_min_us + 1 + $urandom_range(2000), high_max,
                        ($urandom_range(99) < 15) ? int'($urandom_range(7)) : -1);
        end else if (pick < 75) begin
          send_item(OP_SEND, 1'($urandom), 16'($urandom), 8'($urandom));
          while (tx_active) begin
            pick = $urandom_range(24);
            if (pick == 0)
              send_item(OP_SEND, 1'($urandom), 16'($urandom), 8'($urandom));
            else if (pick == 1)
              noise_item();
            else
              carrier_tick();
          end
        end else begin
          repeat ($urandom_range(6, 1)) noise_item();
        end
      end
    end
    sender_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rx_edges();
    test_tx_sequence();
    test_register_extremes();
    test_zero_tick_counts();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
